### hdl/coclustering_probability_residual_top_defines.svh
// Assertion macros for the co-clustering probability block.
// Used by the top level only; no other dependencies.
`ifndef COCLUSTERING_PROBABILITY_RESIDUAL_TOP_DEFINES_SVH
`define COCLUSTERING_PROBABILITY_RESIDUAL_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define CPR_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define CPR_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define CPR_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define CPR_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

### hdl/cpr_pkg.sv
// Shared types and constants for the co-clustering probability block.
// No dependencies; imported by every module of the block but cpr_ram.
package cpr_pkg;

    localparam int MAX_POINTS_DEF = 64;

    localparam int KIND_W     = 2;
    localparam int PTR_W      = 6;
    localparam int LABEL_W    = 16;
    localparam int COUNT_W    = 16;
    localparam int RESULT_W   = 29;
    localparam int CFG_PTS_W  = 7;
    localparam int CFG_BURN_W = 16;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 1;
    localparam int SUM_W      = 48;
    localparam int FRAC_W     = 16;
    localparam int PROB_W     = FRAC_W + 1;
    localparam int RECIP_W    = 32;
    localparam int PROD_W     = COUNT_W + RECIP_W;
    localparam int QR_W       = PROB_W + COUNT_W;
    localparam int SQ_W       = 2 * PROB_W;
    localparam int TERM_W     = SQ_W + 1;

    localparam logic [PROB_W-1:0]    PROB_ONE   = PROB_W'(1) << FRAC_W;
    localparam logic [RESULT_W-1:0]  RESULT_MAX = RESULT_W'(268435456);
    localparam logic [CFG_PTS_W-1:0] PTS_RESET  = CFG_PTS_W'(64);

    typedef enum logic [KIND_W-1:0] {
        KIND_CLEAR = 2'd0,
        KIND_HIST  = 2'd1,
        KIND_RESID = 2'd2,
        KIND_READ  = 2'd3
    } t_kind;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_POINTS = 1'b0,
        CFG_BURN   = 1'b1
    } t_cfg_idx;

    typedef struct packed {
        t_kind               kind;
        logic [PTR_W-1:0]    point_index;
        logic [PTR_W-1:0]    column_index;
        logic [LABEL_W-1:0]  label;
    } t_in_item;

    typedef struct packed {
        logic [RESULT_W-1:0] result_value;
        logic                status;
    } t_out_item;

    typedef struct packed {
        logic accept;
        logic clr_start;
        logic clr_step;
        logic recip_start;
        logic label_wr;
        logic sum_zero;
        logic issue;
        logic row_end;
        logic emit;
    } t_cmd;

    typedef struct packed {
        t_kind kind;
        logic  in_range;
        logic  first_point;
        logic  last_point;
        logic  counting;
        logic  need_recip;
        logic  recip_done;
        logic  sweep_last;
        logic  pipe_empty;
        logic  clr_last;
        logic  out_free;
    } t_stat;

endpackage

### hdl/coclustering_probability_residual_top.sv
// Co-clustering probability block, top level. Depends on cpr_pkg, cpr_ctrl,
// cpr_datapath and the assertion macro header.
// Input channel (i_in_valid / o_in_stall / i_in_item) takes one item at a time:
// clear, history label, residual label or probability read. Output channel
// (o_out_valid / i_out_stall / o_out_item) gives one item for each read and
// for the last point of a residual row. Configuration is a plain write port.
// A counting history or residual label at point p sweeps the pair-count memory
// with one access per point up to and including p; a read makes a single access.
// After the counted row total changes to above one, the first read or residual
// label also waits for the serial reciprocal unit. Uncounted history labels
// skip the sweep; a clear sweeps all 2^(2*clog2(MAX_POINTS)) entries of the
// count memory (4096 by default).
// Reset runs the same sweep with o_in_stall high; configuration writes are
// still taken. A stalled result waits in the output register; the next item
// is still accepted and runs up to its own result, which waits for the slot.
`include "coclustering_probability_residual_top_defines.svh"
module coclustering_probability_residual_top
    import cpr_pkg::*;
#(
    parameter int MAX_POINTS = MAX_POINTS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  t_in_item              i_in_item,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output t_out_item             o_out_item,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cmd  cmd;
    t_stat stat;

    cpr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    cpr_datapath #(
        .MAX_POINTS (MAX_POINTS)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_in_item   (i_in_item),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out_item  (o_out_item)
    );

    `CPR_ASSERT_IMP(a_sweep_stalls_input, i_clk, i_rst_n, cmd.issue, o_in_stall, "item taken during sweep")
    `CPR_ASSERT_IMP(a_emit_slot_free, i_clk, i_rst_n, cmd.emit, stat.out_free, "result overwrites waiting item")
    `CPR_ASSERT_IMP(a_recip_fresh, i_clk, i_rst_n, cmd.issue && (stat.kind != KIND_HIST), !stat.need_recip, "stale reciprocal")
    `CPR_ASSERT_NXT(a_emit_shows, i_clk, i_rst_n, cmd.emit, o_out_valid, "result not presented")

endmodule

### hdl/cpr_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module cpr_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### hdl/cpr_recip.sv
// Bit-serial reciprocal unit: ceil(2^32 / divisor), one quotient bit a cycle.
// Depends on cpr_pkg.
module cpr_recip
    import cpr_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [COUNT_W-1:0] i_divisor,
    output logic               o_done,
    output logic [RECIP_W-1:0] o_recip
);

    localparam int CW = $clog2(RECIP_W);
    localparam logic [CW-1:0] STEP_LAST = CW'(RECIP_W - 1);

    logic               r_busy;
    logic               r_done;
    logic [CW-1:0]      r_cnt;
    logic [COUNT_W-1:0] r_rem;
    logic [RECIP_W-1:0] r_quot;
    logic [COUNT_W:0]   trial;
    logic [COUNT_W:0]   diff;
    logic               ge;
    logic [COUNT_W-1:0] n_rem;

    // dividend is all ones, so every brought-down bit is 1
    assign trial = {r_rem, 1'b1};
    assign diff  = trial - (COUNT_W + 1)'(i_divisor);
    assign ge    = trial >= (COUNT_W + 1)'(i_divisor);
    assign n_rem = ge ? diff[COUNT_W-1:0] : trial[COUNT_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + CW'(1);
                if (r_cnt == STEP_LAST) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= '0;
            r_quot <= '0;
        end else if (r_busy) begin
            r_rem  <= n_rem;
            r_quot <= {r_quot[RECIP_W-2:0], ge};
        end
    end

    assign o_done  = r_done;
    assign o_recip = r_quot + RECIP_W'(1);

endmodule

### hdl/cpr_datapath.sv
// Datapath: config registers, label and pair-count memories, probability and
// residual pipeline, row counters and result register. Depends on cpr_pkg,
// cpr_ram and cpr_recip.
module cpr_datapath
    import cpr_pkg::*;
#(
    parameter int MAX_POINTS = MAX_POINTS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_cmd                  i_cmd,
    output t_stat                 o_stat,
    input  t_in_item              i_in_item,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_out_stall,
    output logic                  o_out_valid,
    output t_out_item             o_out_item
);

    localparam int IW        = $clog2(MAX_POINTS);
    localparam int NW        = $clog2(MAX_POINTS + 1);
    localparam int EW        = (NW > CFG_PTS_W) ? NW : CFG_PTS_W;
    localparam int AW        = 2 * IW;
    localparam int CNT_DEPTH = 1 << AW;
    localparam int SQW       = SUM_W - FRAC_W;
    localparam logic [EW-1:0] N_MAX = EW'(MAX_POINTS);

    // configuration
    logic [CFG_PTS_W-1:0]  r_pts;
    logic [CFG_BURN_W-1:0] r_burn;

    // current item and row state
    t_in_item           r_item;
    logic [COUNT_W-1:0] r_hist;
    logic [COUNT_W-1:0] r_rows;
    logic [SUM_W-1:0]   r_sum;
    logic [RECIP_W-1:0] r_recip;
    logic               r_recip_ok;
    logic [IW-1:0]      r_j;
    logic [AW-1:0]      r_clr_addr;

    logic [EW-1:0] pts_ext;
    logic [EW-1:0] n_eff;
    logic [EW-1:0] pi_ext;
    logic [EW-1:0] ci_ext;
    logic          pi_in;
    logic          ci_in;
    logic [IW-1:0] pi_idx;
    logic [IW-1:0] ci_idx;
    logic [IW-1:0] rd_row;
    logic [IW-1:0] rd_col;
    logic          is_read;
    logic          counting;

    // memories
    logic [AW-1:0]      cnt_raddr;
    logic [AW-1:0]      cnt_waddr;
    logic [COUNT_W-1:0] cnt_wdata;
    logic               cnt_we;
    logic [COUNT_W-1:0] cnt_q;
    logic [LABEL_W-1:0] lab_q;

    logic               recip_done;
    logic [RECIP_W-1:0] recip_val;

    // pipeline
    logic               r_s1_v, r_s1_diag, r_s1_fz;
    logic [AW-1:0]      r_s1_addr;
    logic               same1, bump1, zero1, cap1;
    logic [PROD_W-1:0]  prod1;

    logic               r_s2_v, r_s2_zero, r_s2_cap, r_s2_same, r_s2_dbl;
    logic [COUNT_W-1:0] r_s2_c;
    logic [PROD_W-1:0]  r_s2_prod;
    logic [PROB_W-1:0]  q_est2;
    logic [QR_W-1:0]    qr2;

    logic               r_s3_v, r_s3_zero, r_s3_cap, r_s3_same, r_s3_dbl;
    logic [COUNT_W-1:0] r_s3_c;
    logic [PROB_W-1:0]  r_s3_q;
    logic [QR_W-1:0]    r_s3_qr;
    logic [QR_W-1:0]    num3;
    logic [PROB_W-1:0]  p3;

    logic               r_s4_v, r_s4_same, r_s4_dbl;
    logic [PROB_W-1:0]  r_s4_p;
    logic [PROB_W-1:0]  mag4;
    logic [SQ_W-1:0]    sq4;

    logic               r_s5_v, r_s5_dbl;
    logic [SQ_W-1:0]    r_s5_sq;
    logic [TERM_W-1:0]  term5;
    logic [SUM_W:0]     sum_add;
    logic [SUM_W-1:0]   sum_acc;

    // result
    logic               r_out_valid;
    t_out_item          r_out;
    t_out_item          res;
    logic [SQW-1:0]     sum_q16;
    logic               out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pts  <= PTS_RESET;
            r_burn <= '0;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_POINTS: r_pts  <= i_cfg_data[CFG_PTS_W-1:0];
                CFG_BURN:   r_burn <= i_cfg_data[CFG_BURN_W-1:0];
                default: ;
            endcase
        end
    end

    assign pts_ext  = EW'(r_pts);
    assign n_eff    = (pts_ext == '0) ? EW'(1) : ((pts_ext > N_MAX) ? N_MAX : pts_ext);
    assign pi_ext   = EW'(r_item.point_index);
    assign ci_ext   = EW'(r_item.column_index);
    assign pi_in    = pi_ext < n_eff;
    assign ci_in    = ci_ext < n_eff;
    assign pi_idx   = IW'(r_item.point_index);
    assign ci_idx   = IW'(r_item.column_index);
    assign rd_row   = (pi_idx >= ci_idx) ? pi_idx : ci_idx;
    assign rd_col   = (pi_idx >= ci_idx) ? ci_idx : pi_idx;
    assign is_read  = r_item.kind == KIND_READ;
    assign counting = r_hist >= r_burn;

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_item <= i_in_item;
        end
    end

    // lower triangle only: reads of (i,j) and (j,i) map to the same stored entry
    assign cnt_raddr = is_read ? {rd_row, rd_col} : {pi_idx, r_j};

    cpr_ram #(
        .WIDTH (LABEL_W),
        .DEPTH (MAX_POINTS)
    ) u_label_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.label_wr),
        .i_waddr (pi_idx),
        .i_wdata (r_item.label),
        .i_raddr (r_j),
        .o_rdata (lab_q)
    );

    cpr_ram #(
        .WIDTH (COUNT_W),
        .DEPTH (CNT_DEPTH)
    ) u_count_ram (
        .i_clk   (i_clk),
        .i_we    (cnt_we),
        .i_waddr (cnt_waddr),
        .i_wdata (cnt_wdata),
        .i_raddr (cnt_raddr),
        .o_rdata (cnt_q)
    );

    cpr_recip u_recip (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (i_cmd.recip_start),
        .i_divisor (r_rows),
        .o_done    (recip_done),
        .o_recip   (recip_val)
    );

    // stage 1: memory data back, count update and first multiply
    assign same1 = r_s1_diag || (lab_q == r_item.label);
    assign bump1 = r_s1_v && (r_item.kind == KIND_HIST) && same1 && (cnt_q != '1);
    assign zero1 = (r_rows == '0) || r_s1_fz;
    assign cap1  = cnt_q >= r_rows;
    assign prod1 = PROD_W'(cnt_q) * PROD_W'(r_recip);

    assign cnt_we    = i_cmd.clr_step || bump1;
    assign cnt_waddr = i_cmd.clr_step ? r_clr_addr : r_s1_addr;
    assign cnt_wdata = i_cmd.clr_step ? '0 : cnt_q + COUNT_W'(1);

    // stage 2: quotient estimate, back-multiply
    assign q_est2 = r_s2_prod[FRAC_W +: PROB_W];
    assign qr2    = QR_W'(q_est2) * QR_W'(r_rows);

    // stage 3: correct estimate, apply cap and empty case
    assign num3 = QR_W'({r_s3_c, {FRAC_W{1'b0}}});
    assign p3   = r_s3_zero ? '0 :
                  r_s3_cap  ? PROB_ONE :
                  (r_s3_qr > num3) ? r_s3_q - PROB_W'(1) : r_s3_q;

    // stage 4: squared distance to membership
    assign mag4 = r_s4_same ? PROB_ONE - r_s4_p : r_s4_p;
    assign sq4  = SQ_W'(mag4) * SQ_W'(mag4);

    // stage 5: accumulate, off-diagonal terms count twice
    assign term5   = r_s5_dbl ? {r_s5_sq, 1'b0} : {1'b0, r_s5_sq};
    assign sum_add = {1'b0, r_sum} + (SUM_W + 1)'(term5);
    assign sum_acc = sum_add[SUM_W] ? '1 : sum_add[SUM_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
            r_s2_v <= 1'b0;
            r_s3_v <= 1'b0;
            r_s4_v <= 1'b0;
            r_s5_v <= 1'b0;
        end else begin
            r_s1_v <= i_cmd.issue;
            r_s2_v <= r_s1_v;
            r_s3_v <= r_s2_v;
            r_s4_v <= r_s3_v;
            r_s5_v <= r_s4_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.issue) begin
            r_s1_diag <= r_j == pi_idx;
            r_s1_fz   <= is_read && !(pi_in && ci_in);
            r_s1_addr <= cnt_raddr;
        end
        if (r_s1_v) begin
            r_s2_zero <= zero1;
            r_s2_cap  <= cap1;
            r_s2_same <= same1;
            r_s2_dbl  <= !r_s1_diag;
            r_s2_c    <= cnt_q;
            r_s2_prod <= prod1;
        end
        if (r_s2_v) begin
            r_s3_zero <= r_s2_zero;
            r_s3_cap  <= r_s2_cap;
            r_s3_same <= r_s2_same;
            r_s3_dbl  <= r_s2_dbl;
            r_s3_c    <= r_s2_c;
            r_s3_q    <= q_est2;
            r_s3_qr   <= qr2;
        end
        if (r_s3_v) begin
            r_s4_same <= r_s3_same;
            r_s4_dbl  <= r_s3_dbl;
            r_s4_p    <= p3;
        end
        if (r_s4_v) begin
            r_s5_dbl <= r_s4_dbl;
            r_s5_sq  <= sq4;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_j <= '0;
        end else if (i_cmd.accept) begin
            r_j <= '0;
        end else if (i_cmd.issue) begin
            r_j <= r_j + IW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
        end else if (i_cmd.clr_start) begin
            r_clr_addr <= '0;
        end else if (i_cmd.clr_step) begin
            r_clr_addr <= r_clr_addr + AW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hist     <= '0;
            r_rows     <= '0;
            r_recip_ok <= 1'b0;
        end else if (i_cmd.clr_start) begin
            r_hist     <= '0;
            r_rows     <= '0;
            r_recip_ok <= 1'b0;
        end else if (i_cmd.row_end) begin
            if (r_hist != '1) begin
                r_hist <= r_hist + COUNT_W'(1);
            end
            if (counting && (r_rows != '1)) begin
                r_rows     <= r_rows + COUNT_W'(1);
                r_recip_ok <= 1'b0;
            end
        end else if (recip_done) begin
            r_recip_ok <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_recip <= '0;
        end else if (recip_done) begin
            r_recip <= recip_val;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum <= '0;
        end else if (i_cmd.clr_start || i_cmd.sum_zero) begin
            r_sum <= '0;
        end else if (i_cmd.emit && (r_item.kind == KIND_RESID)) begin
            r_sum <= '0;
        end else if (r_s5_v && (r_item.kind == KIND_RESID)) begin
            r_sum <= sum_acc;
        end
    end

    // result register
    assign sum_q16 = r_sum[SUM_W-1:FRAC_W];

    always_comb begin
        res.status = r_rows == '0;
        if (is_read) begin
            res.result_value = RESULT_W'(r_s4_p);
        end else if (res.status) begin
            res.result_value = '0;
        end else if (sum_q16 > SQW'(RESULT_MAX)) begin
            res.result_value = RESULT_MAX;
        end else begin
            res.result_value = sum_q16[RESULT_W-1:0];
        end
    end

    assign out_free = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out <= res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    always_comb begin
        o_stat.kind        = r_item.kind;
        o_stat.in_range    = pi_in;
        o_stat.first_point = r_item.point_index == '0;
        o_stat.last_point  = pi_ext == (n_eff - EW'(1));
        o_stat.counting    = counting;
        o_stat.need_recip  = !r_recip_ok && (r_rows > COUNT_W'(1));
        o_stat.recip_done  = recip_done;
        o_stat.sweep_last  = is_read || (r_j == pi_idx);
        o_stat.pipe_empty  = !(r_s1_v || r_s2_v || r_s3_v || r_s4_v || r_s5_v);
        o_stat.clr_last    = &r_clr_addr;
        o_stat.out_free    = out_free;
    end

endmodule

### hdl/cpr_ctrl.sv
// Controller: sequences clearing, reciprocal refresh, point sweep, drain and
// result issue for each item. Depends on cpr_pkg.
module cpr_ctrl
    import cpr_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_stall,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    typedef enum logic [6:0] {
        S_CLEAR  = 7'b0000001,
        S_IDLE   = 7'b0000010,
        S_DECIDE = 7'b0000100,
        S_RECIP  = 7'b0001000,
        S_SWEEP  = 7'b0010000,
        S_DRAIN  = 7'b0100000,
        S_FINISH = 7'b1000000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clr_step = 1'b1;
                if (i_stat.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = S_DECIDE;
                end
            end
            S_DECIDE: begin
                case (i_stat.kind)
                    KIND_CLEAR: begin
                        o_cmd.clr_start = 1'b1;
                        n_state         = S_CLEAR;
                    end
                    KIND_HIST: begin
                        if (!i_stat.in_range) begin
                            n_state = S_IDLE;
                        end else begin
                            o_cmd.label_wr = 1'b1;
                            n_state        = i_stat.counting ? S_SWEEP : S_FINISH;
                        end
                    end
                    KIND_RESID, KIND_READ: begin
                        if ((i_stat.kind == KIND_RESID) && !i_stat.in_range) begin
                            n_state = S_IDLE;
                        end else begin
                            if (i_stat.kind == KIND_RESID) begin
                                o_cmd.label_wr = 1'b1;
                                o_cmd.sum_zero = i_stat.first_point;
                            end
                            if (i_stat.need_recip) begin
                                o_cmd.recip_start = 1'b1;
                                n_state           = S_RECIP;
                            end else begin
                                n_state = S_SWEEP;
                            end
                        end
                    end
                    default: n_state = S_IDLE;
                endcase
            end
            S_RECIP: begin
                if (i_stat.recip_done) begin
                    n_state = S_SWEEP;
                end
            end
            S_SWEEP: begin
                o_cmd.issue = 1'b1;
                if (i_stat.sweep_last) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (i_stat.pipe_empty) begin
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                case (i_stat.kind)
                    KIND_HIST: begin
                        o_cmd.row_end = i_stat.last_point;
                        n_state       = S_IDLE;
                    end
                    KIND_RESID, KIND_READ: begin
                        if ((i_stat.kind == KIND_RESID) && !i_stat.last_point) begin
                            n_state = S_IDLE;
                        end else if (i_stat.out_free) begin
                            o_cmd.emit = 1'b1;
                            n_state    = S_IDLE;
                        end
                    end
                    default: n_state = S_IDLE;
                endcase
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_in_stall = r_state != S_IDLE;

endmodule
